>>> rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROW_COUNT  = 25;
	localparam int CELL_COUNT = COLUMNS * ROW_COUNT;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
	localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'd0;
	localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [CHAR_W-1:0] character;
		logic [CHAR_W-1:0] new_color;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              scrolled;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(row) * ADDR_W'(COLUMNS);
		return base + ADDR_W'(col);
	endfunction

endpackage
`default_nettype wire

>>> rtl/tcw_cell_ram.sv
`default_nettype none
module tcw_cell_ram (
	input  wire logic                       clk,
	input  wire tcw_pkg::ram_wr_t           wr,
	input  wire logic                       rd_en,
	input  wire logic [tcw_pkg::ADDR_W-1:0] rd_addr,
	output logic      [tcw_pkg::CELL_W-1:0] rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tcw_pkg::cmd_t              cmd,
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	output tcw_pkg::res_t                   res,
	output logic                            res_pend,
	input  wire logic                       res_take,
	output tcw_pkg::ram_wr_t                wr,
	output logic                            rd_en,
	output logic      [tcw_pkg::ADDR_W-1:0] rd_addr,
	input  wire logic [tcw_pkg::CELL_W-1:0] rd_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FILL,
		ST_COPY,
		ST_BLANK
	} state_t;

	state_t                        state_q;
	logic [tcw_pkg::CNT_W-1:0]     cnt_q;
	logic [tcw_pkg::CHAR_W-1:0]    color_q;
	logic [tcw_pkg::ROW_W-1:0]     row_q;
	logic [tcw_pkg::COL_W-1:0]     col_q;
	tcw_pkg::res_t                 res_q;
	logic                          res_pend_q;

	logic                          accept;
	logic                          is_put;
	logic                          is_newline;
	logic                          read_in_range;
	logic                          wrap;
	logic                          last_row;
	logic [tcw_pkg::ROW_W-1:0]     put_row;
	logic [tcw_pkg::COL_W-1:0]     put_col;
	logic                          put_scroll;
	logic [tcw_pkg::CELL_W-1:0]    blank;

	assign res      = res_q;
	assign res_pend = res_pend_q;

	assign cmd_ready  = (state_q == ST_IDLE) && (!res_pend_q || res_take);
	assign accept     = cmd_valid && cmd_ready;
	assign is_put     = (cmd.func == tcw_pkg::FUNC_PUT) && (cmd.character != tcw_pkg::NULL_CHAR);
	assign is_newline = cmd.character == tcw_pkg::NEWLINE_CHAR;
	assign blank      = {color_q, tcw_pkg::SPACE_CHAR};

	assign read_in_range = (32'(cmd.read_row) < tcw_pkg::ROW_COUNT)
		&& (32'(cmd.read_col) < tcw_pkg::COLUMNS);

	// Cursor step for a put: a newline or the last column wraps to the next row,
	// and wrapping off the last row starts a scroll.
	assign wrap       = is_newline || (32'(col_q) == tcw_pkg::COLUMNS - 1);
	assign last_row   = 32'(row_q) == tcw_pkg::ROW_COUNT - 1;
	assign put_col    = wrap ? '0 : col_q + 1'b1;
	assign put_row    = (wrap && !last_row) ? row_q + 1'b1 : row_q;
	assign put_scroll = wrap && last_row;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = tcw_pkg::cell_addr(cmd.read_row, cmd.read_col);
		wr.en   = 1'b0;
		wr.addr = tcw_pkg::cell_addr(row_q, col_q);
		wr.data = {color_q, cmd.character};
		unique case (state_q)
			ST_IDLE: begin
				rd_en = accept && (cmd.func == tcw_pkg::FUNC_READ) && read_in_range;
				wr.en = accept && is_put && !is_newline;
			end
			ST_READ: begin
			end
			ST_FILL, ST_BLANK: begin
				wr.en   = 1'b1;
				wr.addr = cnt_q[tcw_pkg::ADDR_W-1:0];
				wr.data = blank;
			end
			ST_COPY: begin
				// The read at cnt_q returns next cycle, so each cycle writes the cell
				// returned by the previous read into the row above.
				rd_en   = cnt_q < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT);
				rd_addr = cnt_q[tcw_pkg::ADDR_W-1:0];
				wr.en   = cnt_q > tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
				wr.addr = tcw_pkg::ADDR_W'(cnt_q - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS + 1));
				wr.data = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			cnt_q      <= '0;
			color_q    <= tcw_pkg::RESET_COLOR;
			row_q      <= '0;
			col_q      <= '0;
			res_q      <= '0;
			res_pend_q <= 1'b0;
		end else begin
			if (res_take) begin
				res_pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q.cell_data  <= '0;
						res_q.cursor_row <= row_q;
						res_q.cursor_col <= col_q;
						res_q.scrolled   <= 1'b0;
						res_pend_q       <= 1'b1;
						unique case (cmd.func)
							tcw_pkg::FUNC_PUT: begin
								if (is_put) begin
									row_q            <= put_row;
									col_q            <= put_col;
									res_q.cursor_row <= put_row;
									res_q.cursor_col <= put_col;
									res_q.scrolled   <= put_scroll;
									if (put_scroll) begin
										cnt_q   <= tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
										state_q <= ST_COPY;
									end
								end
							end
							tcw_pkg::FUNC_CLEAR: begin
								color_q          <= cmd.new_color;
								row_q            <= '0;
								col_q            <= '0;
								res_q.cursor_row <= '0;
								res_q.cursor_col <= '0;
								cnt_q            <= '0;
								state_q          <= ST_FILL;
							end
							tcw_pkg::FUNC_READ: begin
								if (read_in_range) begin
									res_pend_q <= 1'b0;
									state_q    <= ST_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					res_q.cell_data <= rd_data;
					res_pend_q      <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
						cnt_q   <= tcw_pkg::CNT_W'((tcw_pkg::ROW_COUNT - 1) * tcw_pkg::COLUMNS);
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/text_console_writer.sv
// Channel  Direction  Handshake             Contents
// s_*      in         s_tvalid / s_tready   command: func, character, color, read position
// m_*      out        m_tvalid / m_tready   result: cell, cursor, scroll flag
//
// A put of an ordinary character is written as it is taken; a read passes through ST_READ (cell memory read port).
// A clear fills all 2000 cells, one per cycle; a put that scrolls runs
// a row copy through the memory read port, then blanks the 80 cells of the bottom row.
// After reset the same fill of all 2000 cells runs before the first command is taken.
// While m_tready is low one result waits in the output register and one more in the
// controller, so one further command is taken before s_tready drops.
`default_nettype none
module text_console_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] character, [15:8] new_color, [20:16] read_row, [27:21] read_col
	input  wire logic [31:0] s_tdata,
	// [1:0] func
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] cell_data, [20:16] cursor_row, [27:21] cursor_col, [28] scrolled
	output logic      [31:0] m_tdata
);

	tcw_pkg::cmd_t                 cmd;
	tcw_pkg::res_t                 res;
	tcw_pkg::ram_wr_t              wr;
	logic                          res_pend;
	logic                          res_take;
	logic                          rd_en;
	logic [tcw_pkg::ADDR_W-1:0]    rd_addr;
	logic [tcw_pkg::CELL_W-1:0]    rd_data;
	logic                          m_tvalid_q;
	logic [31:0]                   m_tdata_q;

	assign cmd.func      = s_tuser;
	assign cmd.character = s_tdata[7:0];
	assign cmd.new_color = s_tdata[15:8];
	assign cmd.read_row  = s_tdata[20:16];
	assign cmd.read_col  = s_tdata[27:21];

	assign res_take = res_pend && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.res       (res),
		.res_pend  (res_pend),
		.res_take  (res_take),
		.wr        (wr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	tcw_cell_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {3'b000, res.scrolled, res.cursor_col, res.cursor_row, res.cell_data};
		end
	end

endmodule
`default_nettype wire
